[rtl/core/fccsw_pkg.sv]
// Shared types, constants and the sequencer program of the cluster chain walker.
package fccsw_pkg;

    // Fixed field widths and chain constants.
    localparam int ClusterW  = 16;
    localparam int SpcW      = 7;
    localparam int LgW       = 4;
    localparam int AddrW     = 32;
    localparam int FsecW     = 8;
    localparam int IdxW      = 11;
    localparam int CntW      = 7;
    localparam int MaxSpc    = 64;
    localparam int LgMin     = 9;
    localparam int LgMax     = 12;
    localparam int PcW       = 3;
    localparam int CfgAddrW  = 2;

    localparam logic [ClusterW-1:0] EndOfChain       = 16'hFFFF;
    localparam logic [AddrW-1:0]    FirstDataCluster = 32'd2;
    localparam logic                OPC_START        = 1'b0;

    // Configuration register indexes.
    typedef enum logic [CfgAddrW-1:0] {
        CFG_FAT_START  = 2'd0,
        CFG_DATA_START = 2'd1,
        CFG_SPC        = 2'd2,
        CFG_LG         = 2'd3
    } cfg_reg_t;

    // Datapath operation selected by one control word.
    typedef enum logic [2:0] {
        UOP_NONE       = 3'd0,
        UOP_SETUP      = 3'd1,
        UOP_BASE       = 3'd2,
        UOP_EMIT_DATA  = 3'd3,
        UOP_EMIT_START = 3'd4
    } uop_t;

    // Jump condition of one control word.
    typedef enum logic [2:0] {
        J_NEXT      = 3'd0,
        J_ALWAYS    = 3'd1,
        J_NO_ACCEPT = 3'd2,
        J_IS_START  = 3'd3,
        J_INACTIVE  = 3'd4,
        J_MORE      = 3'd5
    } jcond_t;

    typedef struct packed {
        logic           in_ready;
        uop_t           uop;
        jcond_t         cond;
        logic [PcW-1:0] target;
    } ctrl_word_t;

    // Program step addresses.
    localparam logic [PcW-1:0] PC_WAIT     = 3'd0;
    localparam logic [PcW-1:0] PC_DISPATCH = 3'd1;
    localparam logic [PcW-1:0] PC_CHECK    = 3'd2;
    localparam logic [PcW-1:0] PC_SETUP    = 3'd3;
    localparam logic [PcW-1:0] PC_BASE     = 3'd4;
    localparam logic [PcW-1:0] PC_EMIT     = 3'd5;
    localparam logic [PcW-1:0] PC_RETURN   = 3'd6;
    localparam logic [PcW-1:0] PC_START    = 3'd7;

    typedef struct packed {
        logic                opcode;
        logic [ClusterW-1:0] first_cluster;
        logic [31:0]         file_size;
        logic [ClusterW-1:0] link_value;
    } in_item_t;

    typedef struct packed {
        logic             data_valid;
        logic [AddrW-1:0] data_sector;
        logic             fetch_valid;
        logic [AddrW-1:0] fetch_sector;
        logic             fetch_read_needed;
        logic [IdxW-1:0]  fetch_entry_index;
        logic             chain_done;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [FsecW-1:0] fsec;
        logic [IdxW-1:0]  idx;
    } fetch_loc_t;

    // The sequencer program: one control word per step.
    function automatic ctrl_word_t ucode(input logic [PcW-1:0] pc);
        ctrl_word_t cw;
        cw = '{in_ready: 1'b0, uop: UOP_NONE, cond: J_NEXT, target: PC_WAIT};
        case (pc)
            PC_WAIT:     cw = '{1'b1, UOP_NONE,       J_NO_ACCEPT, PC_WAIT};
            PC_DISPATCH: cw = '{1'b0, UOP_NONE,       J_IS_START,  PC_START};
            PC_CHECK:    cw = '{1'b0, UOP_NONE,       J_INACTIVE,  PC_WAIT};
            PC_SETUP:    cw = '{1'b0, UOP_SETUP,      J_NEXT,      PC_WAIT};
            PC_BASE:     cw = '{1'b0, UOP_BASE,       J_NEXT,      PC_WAIT};
            PC_EMIT:     cw = '{1'b0, UOP_EMIT_DATA,  J_MORE,      PC_EMIT};
            PC_RETURN:   cw = '{1'b0, UOP_NONE,       J_ALWAYS,    PC_WAIT};
            PC_START:    cw = '{1'b0, UOP_EMIT_START, J_ALWAYS,    PC_WAIT};
            default:     cw = '{1'b0, UOP_NONE,       J_ALWAYS,    PC_WAIT};
        endcase
        return cw;
    endfunction

    // Splits a cluster number into its table sector and the entry inside it.
    function automatic fetch_loc_t fetch_split(input logic [ClusterW-1:0] cluster,
                                               input logic [LgW-1:0] lg);
        fetch_loc_t loc;
        case (lg)
            4'd10:   loc = '{fsec: {1'b0, cluster[15:9]},  idx: {2'b0, cluster[8:0]}};
            4'd11:   loc = '{fsec: {2'b0, cluster[15:10]}, idx: {1'b0, cluster[9:0]}};
            4'd12:   loc = '{fsec: {3'b0, cluster[15:11]}, idx: cluster[10:0]};
            default: loc = '{fsec: cluster[15:8],          idx: {3'b0, cluster[7:0]}};
        endcase
        return loc;
    endfunction

endpackage

[rtl/core/fat16_cluster_chain_sector_walker.sv]
// Top level of the cluster chain walker: sequencer, datapath and result register.
//
// Usage: an item on the s_ channel either starts a chain (opcode 0, first
// cluster and file size) or delivers the table entry of the current cluster
// (opcode 1). A start item gives one result item: the request for the first
// entry (table sector, entry index, read-needed flag), or a done mark when the
// first cluster is the end mark. A link item gives one result item per data
// sector of the current cluster, the last of them carrying the next request
// or the done mark; an empty last cluster gives one item with only the done
// mark. A link item with no chain running gives nothing.
// Steps: a start item passes dispatch and the start step, which registers its
// result; a link item passes dispatch, check, multiply and base add, then one
// emit step per sector, then return and wait. A stalled m_ channel holds the
// result register and freezes the sequencer on either emit step; s_ready is
// high only on the wait step. Reset (aresetn low at a clock edge) restores
// the register defaults, drops any chain and the cached table sector, and
// empties the result register. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while idle, which
// the block itself does not enforce.
module fat16_cluster_chain_sector_walker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fccsw_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [31:0]                          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  fccsw_pkg::in_item_t                  s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output fccsw_pkg::out_item_t                 m_item
);

    // Configuration registers, stored already saturated.
    logic [31:0]                    fat_start_reg, fat_start_next;
    logic [31:0]                    data_start_reg, data_start_next;
    logic [fccsw_pkg::SpcW-1:0]     spc_reg, spc_next;
    logic [fccsw_pkg::LgW-1:0]      lg_reg, lg_next;

    // Chain state.
    logic [fccsw_pkg::ClusterW-1:0] cluster_reg, cluster_next;
    logic [31:0]                    remaining_reg, remaining_next;
    logic [fccsw_pkg::FsecW-1:0]    cached_sector_reg, cached_sector_next;
    logic                           cached_valid_reg, cached_valid_next;
    logic                           active_reg, active_next;

    // Sequencer and datapath registers.
    logic [fccsw_pkg::PcW-1:0]      pc_reg, pc_next;
    fccsw_pkg::in_item_t            in_item_reg, in_item_next;
    logic [31:0]                    prod_reg, prod_next;
    logic [31:0]                    addr_reg, addr_next;
    logic [fccsw_pkg::CntW-1:0]     cnt_reg, cnt_next;
    logic [fccsw_pkg::CntW-1:0]     sec_idx_reg, sec_idx_next;
    logic                           m_valid_reg, m_valid_next;
    fccsw_pkg::out_item_t           m_item_reg, m_item_next;

    fccsw_pkg::ctrl_word_t          cw;
    logic                           s_accept;
    logic                           out_free;
    logic                           stall;
    logic                           take_jump;
    logic                           more;
    logic                           link_end;
    logic [12:0]                    sector_bytes;
    logic [22:0]                    rem_q;
    logic                           rem_frac;
    logic [fccsw_pkg::CntW-1:0]     last_cnt;
    logic [31:0]                    cluster_off;
    fccsw_pkg::fetch_loc_t          link_loc;
    fccsw_pkg::fetch_loc_t          first_loc;
    logic [fccsw_pkg::CntW:0]       sec_idx_inc;

    // Control word decode and handshake.
    assign cw       = fccsw_pkg::ucode(pc_reg);
    assign s_ready  = cw.in_ready;
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = ((cw.uop == fccsw_pkg::UOP_EMIT_DATA) ||
                       (cw.uop == fccsw_pkg::UOP_EMIT_START)) && !out_free;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Sector size and the sector count of a last cluster.
    assign sector_bytes = 13'(1) << lg_reg;
    always_comb begin
        case (lg_reg)
            4'd10:   begin rem_q = {1'b0, remaining_reg[31:10]};
                           rem_frac = |remaining_reg[9:0];  end
            4'd11:   begin rem_q = {2'b0, remaining_reg[31:11]};
                           rem_frac = |remaining_reg[10:0]; end
            4'd12:   begin rem_q = {3'b0, remaining_reg[31:12]};
                           rem_frac = |remaining_reg[11:0]; end
            default: begin rem_q = remaining_reg[31:9];
                           rem_frac = |remaining_reg[8:0];  end
        endcase
    end

    always_comb begin
        if (rem_q >= 23'(spc_reg)) begin
            last_cnt = spc_reg;
        end else begin
            last_cnt = rem_q[fccsw_pkg::CntW-1:0] + fccsw_pkg::CntW'(rem_frac);
        end
    end

    assign link_end    = (in_item_reg.link_value == fccsw_pkg::EndOfChain);
    assign cluster_off = {16'b0, cluster_reg} - fccsw_pkg::FirstDataCluster;
    assign link_loc    = fccsw_pkg::fetch_split(in_item_reg.link_value, lg_reg);
    assign first_loc   = fccsw_pkg::fetch_split(in_item_reg.first_cluster, lg_reg);
    assign sec_idx_inc = {1'b0, sec_idx_reg} + 8'd1;
    assign more        = (cnt_reg != '0) && (sec_idx_inc < {1'b0, cnt_reg});

    // Jump condition.
    always_comb begin
        case (cw.cond)
            fccsw_pkg::J_NEXT:      take_jump = 1'b0;
            fccsw_pkg::J_ALWAYS:    take_jump = 1'b1;
            fccsw_pkg::J_NO_ACCEPT: take_jump = !s_accept;
            fccsw_pkg::J_IS_START:  take_jump = (in_item_reg.opcode == fccsw_pkg::OPC_START);
            fccsw_pkg::J_INACTIVE:  take_jump = !active_reg;
            fccsw_pkg::J_MORE:      take_jump = more;
            default:                take_jump = 1'b0;
        endcase
    end

    // Step counter.
    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (take_jump) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + fccsw_pkg::PcW'(1);
        end
    end

    // Configuration writes, saturated into the legal range.
    always_comb begin
        fat_start_next  = fat_start_reg;
        data_start_next = data_start_reg;
        spc_next        = spc_reg;
        lg_next         = lg_reg;
        if (cfg_we) begin
            case (fccsw_pkg::cfg_reg_t'(cfg_addr))
                fccsw_pkg::CFG_FAT_START:  fat_start_next  = cfg_wdata;
                fccsw_pkg::CFG_DATA_START: data_start_next = cfg_wdata;
                fccsw_pkg::CFG_SPC: begin
                    if (cfg_wdata[6:0] == 7'd0) begin
                        spc_next = 7'd1;
                    end else if (cfg_wdata[6:0] > 7'(fccsw_pkg::MaxSpc)) begin
                        spc_next = 7'(fccsw_pkg::MaxSpc);
                    end else begin
                        spc_next = cfg_wdata[6:0];
                    end
                end
                fccsw_pkg::CFG_LG: begin
                    if (cfg_wdata[3:0] < 4'(fccsw_pkg::LgMin)) begin
                        lg_next = 4'(fccsw_pkg::LgMin);
                    end else if (cfg_wdata[3:0] > 4'(fccsw_pkg::LgMax)) begin
                        lg_next = 4'(fccsw_pkg::LgMax);
                    end else begin
                        lg_next = cfg_wdata[3:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath operations selected by the control word.
    always_comb begin
        in_item_next       = in_item_reg;
        cluster_next       = cluster_reg;
        remaining_next     = remaining_reg;
        cached_sector_next = cached_sector_reg;
        cached_valid_next  = cached_valid_reg;
        active_next        = active_reg;
        prod_next          = prod_reg;
        addr_next          = addr_reg;
        cnt_next           = cnt_reg;
        sec_idx_next       = sec_idx_reg;
        m_item_next        = m_item_reg;
        m_valid_next       = m_valid_reg && !m_ready;

        if (s_accept) begin
            in_item_next = s_item;
        end

        if (!stall) begin
            case (cw.uop)
                fccsw_pkg::UOP_SETUP: begin
                    prod_next    = 32'(32'(spc_reg) * cluster_off);
                    cnt_next     = link_end ? last_cnt : spc_reg;
                    sec_idx_next = '0;
                end
                fccsw_pkg::UOP_BASE: begin
                    addr_next = data_start_reg + prod_reg;
                end
                fccsw_pkg::UOP_EMIT_DATA: begin
                    m_valid_next = 1'b1;
                    m_item_next  = '0;
                    if (cnt_reg != '0) begin
                        m_item_next.data_valid  = 1'b1;
                        m_item_next.data_sector = addr_reg;
                        remaining_next = (remaining_reg > 32'(sector_bytes)) ?
                                         remaining_reg - 32'(sector_bytes) : 32'd0;
                    end
                    addr_next    = addr_reg + 32'd1;
                    sec_idx_next = sec_idx_inc[fccsw_pkg::CntW-1:0];
                    // The final item carries the next request or the done mark.
                    if (!more) begin
                        m_item_next.last = 1'b1;
                        if (link_end) begin
                            active_next                = 1'b0;
                            m_item_next.chain_done     = 1'b1;
                        end else begin
                            cluster_next                  = in_item_reg.link_value;
                            m_item_next.fetch_valid       = 1'b1;
                            m_item_next.fetch_sector      = fat_start_reg +
                                                            32'(link_loc.fsec);
                            m_item_next.fetch_read_needed = !cached_valid_reg ||
                                (cached_sector_reg != link_loc.fsec);
                            m_item_next.fetch_entry_index = link_loc.idx;
                            cached_sector_next            = link_loc.fsec;
                            cached_valid_next             = 1'b1;
                        end
                    end
                end
                fccsw_pkg::UOP_EMIT_START: begin
                    m_valid_next     = 1'b1;
                    m_item_next      = '0;
                    m_item_next.last = 1'b1;
                    cluster_next     = in_item_reg.first_cluster;
                    remaining_next   = in_item_reg.file_size;
                    if (in_item_reg.first_cluster == fccsw_pkg::EndOfChain) begin
                        active_next            = 1'b0;
                        cached_valid_next      = 1'b0;
                        cached_sector_next     = '0;
                        m_item_next.chain_done = 1'b1;
                    end else begin
                        // A new chain always requests a read, whatever table sector was cached.
                        active_next                   = 1'b1;
                        cached_valid_next             = 1'b1;
                        cached_sector_next            = first_loc.fsec;
                        m_item_next.fetch_valid       = 1'b1;
                        m_item_next.fetch_sector      = fat_start_reg + 32'(first_loc.fsec);
                        m_item_next.fetch_read_needed = 1'b1;
                        m_item_next.fetch_entry_index = first_loc.idx;
                    end
                end
                default: ;
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_start_reg     <= '0;
            data_start_reg    <= '0;
            spc_reg           <= 7'd1;
            lg_reg            <= 4'(fccsw_pkg::LgMin);
            cluster_reg       <= '0;
            remaining_reg     <= '0;
            cached_sector_reg <= '0;
            cached_valid_reg  <= 1'b0;
            active_reg        <= 1'b0;
            pc_reg            <= fccsw_pkg::PC_WAIT;
            m_valid_reg       <= 1'b0;
        end else begin
            fat_start_reg     <= fat_start_next;
            data_start_reg    <= data_start_next;
            spc_reg           <= spc_next;
            lg_reg            <= lg_next;
            cluster_reg       <= cluster_next;
            remaining_reg     <= remaining_next;
            cached_sector_reg <= cached_sector_next;
            cached_valid_reg  <= cached_valid_next;
            active_reg        <= active_next;
            pc_reg            <= pc_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        prod_reg    <= prod_next;
        addr_reg    <= addr_next;
        cnt_reg     <= cnt_next;
        sec_idx_reg <= sec_idx_next;
        m_item_reg  <= m_item_next;
    end

endmodule
